/* design/dptp_pkg.sv */
// Package for the decaying priority task picker: table sizes, request and
// status codes, controller states and the structs passed along the cell row.
// No dependencies.
package dptp_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ENERGY_W    = 32;
	localparam int ID_W        = 6;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 3;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [OP_W-1:0] {
		OP_CREATE = 2'd0,
		OP_SCHED  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_CREATED = 3'd0,
		STS_FULL    = 3'd1,
		STS_PICKED  = 3'd2,
		STS_NONE    = 3'd3,
		STS_CLEARED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Running maximum that walks down the cell row during a scan.
	typedef struct packed {
		logic                vld;
		logic                found;
		logic [IDX_W-1:0]    sel;
		logic [ENERGY_W-1:0] best;
	} tok_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic                wr;
		logic [IDX_W-1:0]    idx;
		logic [ENERGY_W-1:0] wdata;
		logic [CNT_W-1:0]    cnt;
	} ctl_t;

endpackage

/* design/decaying_priority_task_picker_core.sv */
// Top level of the decaying priority task picker: the request sequencer and
// a row of TABLE_DEPTH energy cells that pass the scan token one per cycle.
// Depends on dptp_pkg, dptp_cell and dptp_ctrl.
//
//   channel   | direction | tuser           | tdata
//   ----------+-----------+-----------------+-------------------------------
//   s_axis    | in        | [1:0] op        | [31:0] start_energy
//   m_axis    | out       | [2:0] status    | [5:0] task_id, [37:6] energy_left
//
// Create, clear and unused requests go from the result register to the output register.
// A schedule request walks the cell row, one cell per cycle, and its result then
// passes through the result register and the output register.
// One request is in work at a time; the next is taken once the result sits in
// the output register, even while that result waits on m_axis_tready.
// arst_n clears the task count and all handshake state; energies are not reset.
module decaying_priority_task_picker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] start_energy
	input  logic [1:0]  s_axis_tuser,   // [1:0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [5:0] task_id, [37:6] energy_left, [39:38] zero
	output logic [2:0]  m_axis_tuser    // [2:0] status
);
	import dptp_pkg::*;

	ctl_t                ctl;
	tok_t                tok [0:TABLE_DEPTH];
	logic [ID_W-1:0]     rsp_id;
	logic [ENERGY_W-1:0] rsp_energy;

	dptp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_axis_tvalid),
		.req_ready  (s_axis_tready),
		.req_op     (s_axis_tuser),
		.req_energy (s_axis_tdata),
		.rsp_valid  (m_axis_tvalid),
		.rsp_ready  (m_axis_tready),
		.rsp_status (m_axis_tuser),
		.rsp_id     (rsp_id),
		.rsp_energy (rsp_energy),
		.ctl        (ctl),
		.tok_start  (tok[0]),
		.tok_end    (tok[TABLE_DEPTH])
	);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		dptp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.my_idx  (IDX_W'(i)),
			.ctl     (ctl),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	assign m_axis_tdata = {(OUT_TDATA_W - ID_W - ENERGY_W)'(0), rsp_energy, rsp_id};

endmodule

/* design/dptp_cell.sv */
// One table entry of the task picker: holds a task's energy and folds it into
// the running maximum token that passes through on its way down the row.
// Depends on dptp_pkg.
module dptp_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [dptp_pkg::IDX_W-1:0] my_idx,
	input  dptp_pkg::ctl_t        ctl,
	input  dptp_pkg::tok_t        tok_in,
	output dptp_pkg::tok_t        tok_out
);
	import dptp_pkg::*;

	logic [ENERGY_W-1:0] energy_q;
	logic                vld_q;
	logic                found_q;
	logic [IDX_W-1:0]    sel_q;
	logic [ENERGY_W-1:0] best_q;
	logic                active;
	logic                wins;

	assign active = {1'b0, my_idx} < ctl.cnt;
	// Strictly greater keeps the earlier (lower) index on a tie.
	assign wins   = active && (energy_q > tok_in.best);

	always_ff @(posedge clk) begin
		if (ctl.wr && (ctl.idx == my_idx)) begin
			energy_q <= ctl.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (wins) begin
			found_q <= 1'b1;
			sel_q   <= my_idx;
			best_q  <= energy_q;
		end else begin
			found_q <= tok_in.found;
			sel_q   <= tok_in.sel;
			best_q  <= tok_in.best;
		end
	end

	assign tok_out = {vld_q, found_q, sel_q, best_q};

endmodule

/* design/dptp_ctrl.sv */
// Request sequencer of the task picker: task count, create/clear handling,
// scan launch and write-back of the decremented energy, and the result register.
// Depends on dptp_pkg.
module dptp_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [dptp_pkg::OP_W-1:0]      req_op,
	input  logic [dptp_pkg::ENERGY_W-1:0]  req_energy,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [dptp_pkg::STATUS_W-1:0]  rsp_status,
	output logic [dptp_pkg::ID_W-1:0]      rsp_id,
	output logic [dptp_pkg::ENERGY_W-1:0]  rsp_energy,
	output dptp_pkg::ctl_t                 ctl,
	output dptp_pkg::tok_t                 tok_start,
	input  dptp_pkg::tok_t                 tok_end
);
	import dptp_pkg::*;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	status_t              res_status_q;
	logic [ID_W-1:0]      res_id_q;
	logic [ENERGY_W-1:0]  res_energy_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [ID_W-1:0]      out_id_q;
	logic [ENERGY_W-1:0]  out_energy_q;
	logic                 accept;
	logic                 has_room;
	logic                 scan_done;
	logic                 out_free;
	logic [ENERGY_W-1:0]  best_dec;
	op_t                  op;

	assign op        = op_t'(req_op);
	assign accept    = req_valid && req_ready;
	assign has_room  = cnt_q < CNT_W'(TABLE_DEPTH);
	assign scan_done = (state_q == ST_SCAN) && tok_end.vld;
	assign out_free  = !out_valid_q || rsp_ready;
	assign best_dec  = tok_end.best - ENERGY_W'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (op == OP_SCHED) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (tok_end.vld) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready       = (state_q == ST_IDLE);
		tok_start.vld   = accept && (op == OP_SCHED);
		tok_start.found = 1'b0;
		tok_start.sel   = '0;
		tok_start.best  = '0;
		ctl.cnt         = cnt_q;
		ctl.wr          = 1'b0;
		ctl.idx         = cnt_q[IDX_W-1:0];
		ctl.wdata       = req_energy;
		// The scan token is back only in ST_SCAN, so the two writes never meet.
		if (scan_done) begin
			ctl.wr    = tok_end.found;
			ctl.idx   = tok_end.sel;
			ctl.wdata = best_dec;
		end else if (accept && (op == OP_CREATE) && has_room) begin
			ctl.wr = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (op == OP_CREATE) && has_room) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (accept && (op == OP_CLEAR)) begin
				cnt_q <= '0;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (op)
				OP_CREATE: begin
					if (has_room) begin
						res_status_q <= STS_CREATED;
						res_id_q     <= ID_W'(cnt_q + CNT_W'(1));
						res_energy_q <= req_energy;
					end else begin
						res_status_q <= STS_FULL;
						res_id_q     <= '0;
						res_energy_q <= '0;
					end
				end
				OP_CLEAR: begin
					res_status_q <= STS_CLEARED;
					res_id_q     <= '0;
					res_energy_q <= '0;
				end
				default: begin
					res_status_q <= STS_NONE;
					res_id_q     <= '0;
					res_energy_q <= '0;
				end
			endcase
		end else if (scan_done) begin
			if (tok_end.found) begin
				res_status_q <= STS_PICKED;
				res_id_q     <= ID_W'({1'b0, tok_end.sel} + (IDX_W + 1)'(1));
				res_energy_q <= best_dec;
			end else begin
				res_status_q <= STS_NONE;
				res_id_q     <= '0;
				res_energy_q <= '0;
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_energy_q <= res_energy_q;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_id     = out_id_q;
	assign rsp_energy = out_energy_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("task count exceeds the table depth");

	a_tok_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.vld |-> (state_q == ST_SCAN))
		else $error("scan token returned outside a scan");

	a_sched_scans: assert property (@(posedge clk) disable iff (!arst_n)
		tok_start.vld |=> (state_q == ST_SCAN))
		else $error("schedule request did not start a scan");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && out_free) |=> (rsp_valid && (state_q == ST_IDLE)))
		else $error("finished result was not presented");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for decaying_priority_task_picker_core: a task table
// tracker predicts every answer, random gaps and stalls hit both streams.
// Depends on dptp_pkg and the core RTL only.
module testbench;
	import dptp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1500;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     task_id;
		logic [ENERGY_W-1:0] energy_left;
	} answer_t;

	// Mirrors the table contents and the task count, and keeps the answers
	// still owed by the core in request order.
	class task_table_tracker;
		logic [ENERGY_W-1:0] energy [TABLE_DEPTH];
		int unsigned         count;
		answer_t             awaited_answers [$];
		int                  errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		function void note_request(op_t op, logic [ENERGY_W-1:0] init_energy);
			answer_t             ans;
			logic [ENERGY_W-1:0] best;
			int unsigned         sel;
			bit                  found;
			ans = '{STS_NONE, '0, '0};
			best = '0;
			sel = 0;
			found = 0;
			case (op)
				OP_CREATE: begin
					if (count >= TABLE_DEPTH) begin
						ans.status = STS_FULL;
					end else begin
						energy[count] = init_energy;
						count++;
						ans = '{STS_CREATED, ID_W'(count), init_energy};
					end
				end
				OP_SCHED: begin
					// Strictly greater wins, so ties stay with the lowest index.
					for (int i = 0; i < count; i++) begin
						if (energy[i] > best) begin
							best = energy[i];
							sel = i;
							found = 1;
						end
					end
					if (found) begin
						energy[sel] = best - 1;
						ans = '{STS_PICKED, ID_W'(sel + 1), best - 1};
					end
				end
				OP_CLEAR: begin
					count = 0;
					ans.status = STS_CLEARED;
				end
				default: begin
				end
			endcase
			awaited_answers.push_back(ans);
		endfunction

		function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] task_id,
				logic [ENERGY_W-1:0] energy_left);
			answer_t want;
			if (awaited_answers.size() == 0) begin
				$error("result with no request pending: status %0d task_id %0d energy_left %0h",
					status, task_id, energy_left);
				errors++;
				return;
			end
			want = awaited_answers.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, status);
				errors++;
			end
			if (task_id !== want.task_id) begin
				$error("task_id: expected %0d, actual %0d", want.task_id, task_id);
				errors++;
			end
			if (energy_left !== want.energy_left) begin
				$error("energy_left: expected %0h, actual %0h", want.energy_left, energy_left);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	task_table_tracker tracker = new();
	bit                no_idle = 0;
	int unsigned       cycles = 0;

	decaying_priority_task_picker_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("decaying_priority_task_picker_core: mismatch");
			$finish;
		end
	end

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic logic [31:0] draw_energy();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			2: return '0;
			default: return $urandom_range(0, 6);
		endcase
	endfunction

	// Valid stays high across back-to-back requests when the drawn gap is zero.
	task automatic send_request(input op_t op, input logic [31:0] init_energy);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= init_energy;
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_request(op, init_energy);
	endtask

	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			tracker.check_result(m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[37:6]);
		end
	end

	initial begin
		int   sent;
		int   n_create;
		int   n_sched;
		op_t  op;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_CREATE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, unused op and clear on nothing.
		send_request(OP_SCHED, 32'h0);
		send_request(OP_UNUSED, 32'hFFFF_FFFF);
		send_request(OP_CLEAR, 32'h0);
		// A zero-energy task is never picked.
		send_request(OP_CREATE, 32'h0);
		send_request(OP_SCHED, 32'h0);
		// Two maximal tasks: ties go to the lower index, then decay alternates.
		send_request(OP_CREATE, 32'hFFFF_FFFF);
		send_request(OP_CREATE, 32'hFFFF_FFFF);
		send_request(OP_SCHED, 32'h0);
		send_request(OP_SCHED, 32'h0);
		send_request(OP_SCHED, 32'h0);
		send_request(OP_CREATE, 32'h1);
		send_request(OP_CREATE, 32'h8000_0000);
		send_request(OP_UNUSED, 32'hAAAA_AAAA);
		send_request(OP_SCHED, 32'h5555_5555);
		// After a clear the old entries must stay invisible.
		send_request(OP_CLEAR, 32'hFFFF_FFFF);
		send_request(OP_SCHED, 32'h0);
		send_request(OP_CREATE, 32'h1);
		send_request(OP_SCHED, 32'h0);
		send_request(OP_SCHED, 32'h0);

		sent = 0;
		while (sent < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0) begin
				send_request(OP_CLEAR, $urandom);
				sent++;
			end
			// Some phases push well past a full table.
			n_create = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 36)
				: $urandom_range(0, 8);
			n_sched = $urandom_range(0, 24);
			repeat (n_create) begin
				send_request(OP_CREATE, draw_energy());
				sent++;
			end
			repeat (n_sched) begin
				if ($urandom_range(0, 9) == 0) begin
					op = op_t'($urandom_range(0, 3));
					send_request(op, $urandom);
					if (op != OP_UNUSED)
						sent++;
				end else begin
					send_request(OP_SCHED, $urandom);
					sent++;
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		while (tracker.awaited_answers.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.errors == 0)
			$display("decaying_priority_task_picker_core: match");
		else
			$display("decaying_priority_task_picker_core: mismatch");
		$finish;
	end

endmodule

/* files.f */
design/dptp_pkg.sv
design/dptp_cell.sv
design/dptp_ctrl.sv
design/decaying_priority_task_picker_core.sv
bench/testbench.sv
